// ===== src/cnsp_pkg.sv =====
// Shared types, codes and character tables for the cpio newc stream parser.
package cnsp_pkg;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_RECORD  = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  localparam int unsigned HDR_LEN     = 110;
  localparam int unsigned MAGIC_LEN   = 6;
  localparam int unsigned TRAILER_LEN = 10;
  // last digit of the filesize and namesize fields within the header
  localparam int unsigned FSIZE_LAST  = 61;
  localparam int unsigned NSIZE_LAST  = 101;

  typedef struct packed {
    logic       start_of_archive;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [31:0] file_size;
    logic [31:0] name_size;
    logic [31:0] data_offset;
  } res_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h41 + 8'd10);
    else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h61 + 8'd10);
    return v;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54; // T
      4'd1:    c = 8'h52; // R
      4'd2:    c = 8'h41; // A
      4'd3:    c = 8'h49; // I
      4'd4:    c = 8'h4c; // L
      4'd5:    c = 8'h45; // E
      4'd6:    c = 8'h52; // R
      4'd7:    c = 8'h21; // !
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/cpio_newc_stream_parser.sv =====
// Top level of the cpio newc stream parser: input register, decode step, result buffer.
//
// Feed the archive one byte per item on the in_ channel; set in_start_of_archive
// on the first byte of each archive to restart parsing from position zero.
// Results leave on the out_ channel: name characters, one entry record per file
// (sizes and the 4-aligned data offset), a trailer mark or a bad-magic mark.
// Bytes that produce nothing (header digits, padding, file data) are consumed
// silently. After a trailer or bad magic all bytes are dropped until the next
// start byte.
// A result passes the input register and then the result buffer before it is valid
// at the out_ ports. Throughput: one byte per cycle while the result buffer has room;
// every byte passes one register stage and one decode step, and the decode
// state updates once per byte.
// The result buffer holds two items; when out_stall holds it full, in_stall
// rises and the byte held in the input register waits.
// Reset (rst_n low, synchronous) empties both stages and returns the parser to
// the magic phase at position zero, as if an archive had started.
module cpio_newc_stream_parser #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_of_archive,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_name_char,
  output logic [31:0] out_file_size,
  output logic [31:0] out_name_size,
  output logic [31:0] out_data_offset
);

  cnsp_pkg::in_item_t item_r;
  logic               item_v_r, item_v_nxt;
  logic               fifo_full, fifo_ne, res_push, step_fire, in_fire, out_fire;
  cnsp_pkg::res_t     res_data, head;

  // advance the held byte whenever the result buffer has room
  assign step_fire  = item_v_r && !fifo_full;
  assign in_stall   = item_v_r && fifo_full;
  assign in_fire    = in_valid && !in_stall;
  assign item_v_nxt = in_fire || (item_v_r && !step_fire);
  assign out_fire   = fifo_ne && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.start_of_archive <= in_start_of_archive;
      item_r.byte_value       <= in_byte_value;
    end
  end

  cnsp_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_fire(step_fire),
    .step_item(item_r),
    .res_push (res_push),
    .res_data (res_data)
  );

  cnsp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .pop      (out_fire),
    .full     (fifo_full),
    .not_empty(fifo_ne),
    .head     (head)
  );

  assign out_valid       = fifo_ne;
  assign out_kind        = head.kind;
  assign out_name_char   = head.name_char;
  assign out_file_size   = head.file_size;
  assign out_name_size   = head.name_size;
  assign out_data_offset = head.data_offset;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_v_r && fifo_full)
    else $error("input stalled without a full result buffer");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    item_v_r && !step_fire |=> item_v_r)
    else $error("held byte lost while waiting");

  a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> step_fire)
    else $error("result pushed without a byte");

endmodule

// ===== src/cnsp_step.sv =====
// Parser state and the per-byte decode step that produces at most one result.
module cnsp_step #(
  parameter int POSITION_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_fire,
  input  cnsp_pkg::in_item_t step_item,
  output logic              res_push,
  output cnsp_pkg::res_t    res_data
);

  typedef enum logic [1:0] {PH_MAGIC, PH_HEADER, PH_NAME, PH_SKIP} phase_t;

  localparam int RELW  = 34;
  localparam int SKIPW = 35;

  phase_t                   phase_r, phase_nxt, c_phase;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, c_pos;
  logic [POSITION_BITS-1:0] es_r, es_nxt, c_es;
  logic [31:0]              fc_r, fc_nxt, c_fc;
  logic [31:0]              acc_r, acc_nxt, c_acc;
  logic [31:0]              ns_r, ns_nxt, c_ns;
  logic [31:0]              fs_r, fs_nxt, c_fs;
  logic [RELW-1:0]          rel_r, rel_nxt;
  logic [SKIPW-1:0]         skip_r, skip_nxt;
  logic                     mok_r, mok_nxt, c_mok;
  logic                     trl_r, trl_nxt, c_trl;
  logic                     ended_r, ended_nxt, c_ended;
  logic                     halted_r, halted_nxt, c_halted;
  logic                     go, do_finish, push;
  logic [2:0]               digit_idx;
  logic [POSITION_BITS-1:0] data_pos;
  logic [7:0]               b;
  cnsp_pkg::res_t           res;

  always_comb begin
    b = step_item.byte_value;
    // a start byte sees the reset state
    c_phase  = step_item.start_of_archive ? PH_MAGIC : phase_r;
    c_pos    = step_item.start_of_archive ? '0 : pos_r;
    c_es     = step_item.start_of_archive ? '0 : es_r;
    c_fc     = step_item.start_of_archive ? '0 : fc_r;
    c_acc    = step_item.start_of_archive ? '0 : acc_r;
    c_ns     = step_item.start_of_archive ? '0 : ns_r;
    c_fs     = step_item.start_of_archive ? '0 : fs_r;
    c_mok    = step_item.start_of_archive ? 1'b1 : mok_r;
    c_trl    = step_item.start_of_archive ? 1'b1 : trl_r;
    c_ended  = step_item.start_of_archive ? 1'b0 : ended_r;
    c_halted = step_item.start_of_archive ? 1'b0 : halted_r;

    phase_nxt  = c_phase;
    pos_nxt    = c_pos;
    es_nxt     = c_es;
    fc_nxt     = c_fc;
    acc_nxt    = c_acc;
    ns_nxt     = c_ns;
    fs_nxt     = c_fs;
    mok_nxt    = c_mok;
    trl_nxt    = c_trl;
    ended_nxt  = c_ended;
    halted_nxt = c_halted;
    rel_nxt    = rel_r;
    skip_nxt   = skip_r;
    go         = 1'b0;
    do_finish  = 1'b0;
    push       = 1'b0;
    digit_idx  = c_fc[2:0] - 3'(cnsp_pkg::MAGIC_LEN);
    data_pos   = c_es + POSITION_BITS'(rel_r);
    res        = '0;

    if (!c_halted) begin
      pos_nxt = c_pos + POSITION_BITS'(1);
      go = 1'b1;
      if (c_phase == PH_SKIP) begin
        if (c_pos != c_es) begin
          go = 1'b0;
        end else begin
          phase_nxt = PH_MAGIC;
          fc_nxt    = '0;
          mok_nxt   = 1'b1;
        end
      end
    end

    if (go) begin
      unique case (phase_nxt)
        PH_MAGIC: begin
          if (b != cnsp_pkg::magic_char(fc_nxt[2:0])) mok_nxt = 1'b0;
          fc_nxt = fc_nxt + 32'd1;
          if (fc_nxt >= 32'(cnsp_pkg::MAGIC_LEN)) begin
            if (!mok_nxt) begin
              push       = 1'b1;
              res.kind   = cnsp_pkg::KIND_BAD;
              halted_nxt = 1'b1;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          acc_nxt = ((digit_idx == 3'd0) ? 32'd0 : c_acc << 4)
                    | 32'(cnsp_pkg::hex_nibble(b));
          if (c_fc == 32'(cnsp_pkg::FSIZE_LAST)) fs_nxt = acc_nxt;
          if (c_fc == 32'(cnsp_pkg::NSIZE_LAST)) begin
            ns_nxt  = acc_nxt;
            rel_nxt = (RELW'(acc_nxt) + RELW'(cnsp_pkg::HDR_LEN + 3)) & ~RELW'(3);
          end
          // name and file sizes are settled: precompute the entry length
          if (c_fc == 32'(cnsp_pkg::NSIZE_LAST + 1)) begin
            skip_nxt = (SKIPW'(rel_r) + SKIPW'(c_fs) + SKIPW'(3)) & ~SKIPW'(3);
          end
          fc_nxt = c_fc + 32'd1;
          if (fc_nxt >= 32'(cnsp_pkg::HDR_LEN)) begin
            fc_nxt    = '0;
            trl_nxt   = 1'b1;
            ended_nxt = 1'b0;
            if (c_ns == 32'd0) begin
              trl_nxt   = 1'b0;
              do_finish = 1'b1;
            end else begin
              phase_nxt = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (c_fc == c_ns - 32'd1) begin
            if (!c_ended && c_fc != 32'(cnsp_pkg::TRAILER_LEN)) trl_nxt = 1'b0;
            do_finish = 1'b1;
          end else begin
            fc_nxt = c_fc + 32'd1;
            if (!c_ended) begin
              if (b == 8'd0) begin
                ended_nxt = 1'b1;
                if (c_fc != 32'(cnsp_pkg::TRAILER_LEN)) trl_nxt = 1'b0;
              end else begin
                if (c_fc < 32'(cnsp_pkg::TRAILER_LEN)) begin
                  if (b != cnsp_pkg::trailer_char(c_fc[3:0])) trl_nxt = 1'b0;
                end else begin
                  trl_nxt = 1'b0;
                end
                push          = 1'b1;
                res.kind      = cnsp_pkg::KIND_NAME;
                res.name_char = b;
              end
            end
          end
        end
        PH_SKIP: begin
          go = 1'b1;
        end
        default: begin
          go = 1'b1;
        end
      endcase
    end

    if (do_finish) begin
      push = 1'b1;
      if (trl_nxt) begin
        res.kind   = cnsp_pkg::KIND_TRAILER;
        halted_nxt = 1'b1;
      end else begin
        res.kind        = cnsp_pkg::KIND_RECORD;
        res.file_size   = c_fs;
        res.name_size   = c_ns;
        res.data_offset = 32'(data_pos);
        es_nxt          = c_es + POSITION_BITS'(skip_r);
        phase_nxt       = PH_SKIP;
      end
    end
  end

  assign res_push = step_fire && push;
  assign res_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      pos_r    <= '0;
      es_r     <= '0;
      fc_r     <= '0;
      acc_r    <= '0;
      ns_r     <= '0;
      fs_r     <= '0;
      mok_r    <= 1'b1;
      trl_r    <= 1'b1;
      ended_r  <= 1'b0;
      halted_r <= 1'b0;
    end else if (step_fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      es_r     <= es_nxt;
      fc_r     <= fc_nxt;
      acc_r    <= acc_nxt;
      ns_r     <= ns_nxt;
      fs_r     <= fs_nxt;
      mok_r    <= mok_nxt;
      trl_r    <= trl_nxt;
      ended_r  <= ended_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      rel_r  <= rel_nxt;
      skip_r <= skip_nxt;
    end
  end

  a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && (res_data.kind == cnsp_pkg::KIND_BAD || res_data.kind == cnsp_pkg::KIND_TRAILER)
    |=> halted_r)
    else $error("archive end did not halt the parser");

  a_record_skips: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_data.kind == cnsp_pkg::KIND_RECORD |=> phase_r == PH_SKIP)
    else $error("entry record not followed by skip phase");

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && step_fire && !step_item.start_of_archive |-> !res_push)
    else $error("result produced while halted");

endmodule

// ===== src/cnsp_out_fifo.sv =====
// Two-entry result buffer between the decode step and the output channel.
module cnsp_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cnsp_pkg::res_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output cnsp_pkg::res_t head
);

  cnsp_pkg::res_t mem_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full result buffer");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("pop from empty result buffer");

endmodule
